[rtl/depq_pkg.sv]
package depq_pkg;

   localparam int VALUE_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEL_MAX = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL_MIN = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] max_value;
      logic signed [VALUE_W-1:0] min_value;
      logic [COUNT_W-1:0]        entry_count;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   // per-cycle command broadcast along one cell row
   typedef struct packed {
      logic insert;   // place the new value in order
      logic shift;    // drop the head, move every entry one cell toward it
   } cell_ctrl_type;

endpackage

[rtl/depq_cell.sv]
module depq_cell
   import depq_pkg::*;
#(
   parameter int CNT_W      = 7,
   parameter int INDEX      = 0,
   parameter bit DESCENDING = 1'b0
) (
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] new_value,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic                      prev_after,
   input  logic signed [VALUE_W-1:0] next_value,
   output logic signed [VALUE_W-1:0] value,
   output logic                      after
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      occupied;
   logic                      beyond;

   assign occupied = count > CNT_W'(INDEX);
   assign beyond   = DESCENDING ? (value_ff < new_value) : (value_ff > new_value);
   // an empty cell ranks after any value
   assign after    = !occupied || beyond;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (after) begin
            value_in = prev_after ? prev_value : new_value;
         end
      end else if (ctrl.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[rtl/depq_chain.sv]
module depq_chain
   import depq_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int CNT_W      = 7,
   parameter bit DESCENDING = 1'b0
) (
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] new_value,
   input  logic [CNT_W-1:0]          count,
   output logic signed [VALUE_W-1:0] head_value
);

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic                      cell_after [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value;
      logic                      prev_after;
      logic signed [VALUE_W-1:0] next_value;

      if (i == 0) begin : g_first
         assign prev_value = '0;
         assign prev_after = 1'b0;
      end else begin : g_mid
         assign prev_value = cell_value[i-1];
         assign prev_after = cell_after[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      depq_cell #(
         .CNT_W      (CNT_W),
         .INDEX      (i),
         .DESCENDING (DESCENDING)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_value  (new_value),
         .count      (count),
         .prev_value (prev_value),
         .prev_after (prev_after),
         .next_value (next_value),
         .value      (cell_value[i]),
         .after      (cell_after[i])
      );
   end

   assign head_value = cell_value[0];

endmodule

[rtl/double_ended_priority_queue.sv]
// Double-ended priority queue of signed 32-bit values, up to CAPACITY entries.
// Each transaction (start high while busy is low) inserts a value, deletes the
// maximum or deletes the minimum; func 3 acts as delete minimum. Exactly one
// result follows each transaction: rsp_strobe is high for one cycle, the cycle
// right after the transaction, with the new maximum and minimum (0 when empty),
// the entry count and a status (done, delete on empty ignored, insert dropped
// because full). The receiver cannot stall, so results are never held. A new
// transaction is taken in every cycle, and busy is high only during reset. The
// queue keeps two rows of CAPACITY cells, one sorted ascending and one
// descending, that each settle an insert or a head deletion. Storage is not
// cleared at reset; only the count and the result strobe are.
module double_ended_priority_queue
   import depq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic             accept;
   logic             is_insert;
   logic             is_del_max;
   logic             is_full;
   logic             is_empty;
   logic             do_insert;
   logic             do_delete;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic                strobe_ff;
   logic                strobe_in;

   cell_ctrl_type             asc_ctrl;
   cell_ctrl_type             desc_ctrl;
   logic signed [VALUE_W-1:0] asc_head;
   logic signed [VALUE_W-1:0] desc_head;
   logic [31:0]               count_wide;

   // hold off transactions only while in reset
   assign busy   = reset;
   assign accept = start && !busy;

   assign is_insert  = req_data.func == FUNC_INSERT;
   assign is_del_max = req_data.func == FUNC_DEL_MAX;
   assign is_full    = count_ff == CNT_W'(CAPACITY);
   assign is_empty   = count_ff == '0;

   // drop inserts into a full queue and deletes from an empty one
   assign do_insert = accept && is_insert && !is_full;
   assign do_delete = accept && !is_insert && !is_empty;

   // Both rows hold the same multiset. A deletion shifts the row whose head
   // is the deleted end; the other row simply loses its last entry through
   // the count.
   always_comb begin
      asc_ctrl.insert  = do_insert;
      asc_ctrl.shift   = do_delete && !is_del_max;
      desc_ctrl.insert = do_insert;
      desc_ctrl.shift  = do_delete && is_del_max;
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_delete) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      status_in = STATUS_DONE;
      if (is_insert && is_full) begin
         status_in = STATUS_FULL;
      end else if (!is_insert && is_empty) begin
         status_in = STATUS_EMPTY;
      end
   end

   assign strobe_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   depq_chain #(
      .CAPACITY   (CAPACITY),
      .CNT_W      (CNT_W),
      .DESCENDING (1'b0)
   ) u_asc_chain (
      .clock      (clock),
      .ctrl       (asc_ctrl),
      .new_value  (req_data.value),
      .count      (count_ff),
      .head_value (asc_head)
   );

   depq_chain #(
      .CAPACITY   (CAPACITY),
      .CNT_W      (CNT_W),
      .DESCENDING (1'b1)
   ) u_desc_chain (
      .clock      (clock),
      .ctrl       (desc_ctrl),
      .new_value  (req_data.value),
      .count      (count_ff),
      .head_value (desc_head)
   );

   // report the count masked to the result field width
   assign count_wide = 32'(count_ff);

   always_comb begin
      rsp_data.max_value   = (count_ff == '0) ? '0 : desc_head;
      rsp_data.min_value   = (count_ff == '0) ? '0 : asc_head;
      rsp_data.entry_count = count_wide[COUNT_W-1:0];
      rsp_data.status      = status_ff;
   end

   assign rsp_strobe = strobe_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("transaction without result");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result without transaction");

   a_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && count_ff != '0) |-> (rsp_data.min_value <= rsp_data.max_value))
      else $error("minimum above maximum");

   a_full_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_FULL) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("full status while not full");

endmodule
